[design/gbpb_pkg.sv]
// Package for the graphics byte-to-pixel-block decoder.
// Holds the transfer structs, register codes and colour tables.
// No dependencies.
package gbpb_pkg;

  typedef struct packed {
    logic [10:0] byte_offset;
    logic [7:0]  mem_byte;
  } in_t;

  typedef struct packed {
    logic [6:0]  block_x;
    logic [6:0]  block_y;
    logic [2:0]  block_side;
    logic [15:0] pixel_color;
    logic        last_block;
  } out_t;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_C444   = 1'b1;

  localparam int FMT_FINE = 6;
  localparam int FMT_BIG  = 5;
  localparam int FMT_COL  = 4;

  localparam logic [15:0] TAB565_COL [16] = '{
    16'h0000, 16'h8000, 16'h0400, 16'h8400, 16'h0010, 16'h8010, 16'h0410, 16'h8410,
    16'h0000, 16'hf800, 16'h07e0, 16'hffe0, 16'h001f, 16'hf81f, 16'h07ff, 16'hffff
  };
  localparam logic [15:0] TAB565_GRAY [16] = '{
    16'h0000, 16'h1082, 16'h2104, 16'h31a6, 16'h4228, 16'h52aa, 16'h632c, 16'h73ae,
    16'h8c51, 16'h9cd3, 16'had55, 16'hbdd7, 16'hce59, 16'hdefb, 16'hef7d, 16'hffff
  };
  localparam logic [15:0] TAB444_COL [16] = '{
    16'h0000, 16'h0800, 16'h0080, 16'h0880, 16'h0008, 16'h0808, 16'h0088, 16'h0888,
    16'h0000, 16'h0f00, 16'h00f0, 16'h0ff0, 16'h000f, 16'h0f0f, 16'h00ff, 16'h0fff
  };
  localparam logic [15:0] TAB444_GRAY [16] = '{
    16'h0000, 16'h0111, 16'h0222, 16'h0333, 16'h0444, 16'h0555, 16'h0666, 16'h0777,
    16'h0888, 16'h0999, 16'h0aaa, 16'h0bbb, 16'h0ccc, 16'h0ddd, 16'h0eee, 16'h0fff
  };

  function automatic logic [15:0] lookup(logic [3:0] idx, logic col, logic c444);
    logic [15:0] v;
    if (c444) begin
      v = col ? TAB444_COL[idx] : TAB444_GRAY[idx];
    end else begin
      v = col ? TAB565_COL[idx] : TAB565_GRAY[idx];
    end
    return v;
  endfunction

endpackage

[design/graphics_byte_to_pixel_blocks.sv]
// Top level of the graphics byte-to-pixel-block decoder.
// Uses gbpb_pkg for transfer structs and colour tables.
// The accepted byte is registered in item_r, and each block is registered in out_r for the result ports.
// Throughput: one block per cycle while a byte is held; a byte yields 8 blocks in fine mode, 2 in coarse,
// none when dropped (512-byte mode, offset 512 or above); set by the block counter.
// Next byte is taken on the cycle the last block of the current one is formed.
// Reset (synchronous, rst_n low) clears config, valid, counter and strobe; no stall.
module graphics_byte_to_pixel_blocks import gbpb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] format_r;
  logic       c444_r;
  in_t        item_r, item_nxt;
  logic       val_r, val_nxt;
  logic [2:0] k_r, k_nxt;
  logic       out_valid_r;
  out_t       out_r, out_nxt;

  logic       fine, big, last_now, accept;
  logic [1:0] q;
  logic [4:0] row;
  logic [3:0] col;
  logic [7:0] bx, by;
  logic [15:0] fg;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_C444) ? {31'd0, c444_r} : {24'd0, format_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= 8'd0;
      c444_r   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_FORMAT: format_r <= pwdata[7:0];
        REG_C444:   c444_r   <= pwdata[0];
      endcase
    end
  end

  assign fine = format_r[FMT_FINE];
  assign big  = format_r[FMT_BIG];
  assign q    = item_r.byte_offset[10:9];
  assign row  = item_r.byte_offset[8:4];
  assign col  = item_r.byte_offset[3:0];
  assign fg   = lookup(format_r[3:0], format_r[FMT_COL], c444_r);

  assign last_now = fine ? (k_r == 3'd7) : (k_r == 3'd1);
  assign busy     = val_r && !last_now;
  assign accept   = start && !busy;

  always_comb begin
    item_nxt = item_r;
    val_nxt  = val_r;
    k_nxt    = k_r;
    if (val_r) begin
      k_nxt = k_r + 3'd1;
      if (last_now) begin
        val_nxt = 1'b0;
      end
    end
    if (accept) begin
      item_nxt = in_data;
      val_nxt  = big || (in_data.byte_offset[10:9] == 2'd0);
      k_nxt    = 3'd0;
    end
  end

  always_comb begin
    bx = 8'd0;
    by = 8'd0;
    out_nxt = '0;
    if (fine) begin
      bx = {2'd0, col, k_r[2], k_r[0]};
      by = {2'd0, row, k_r[1]};
      if (big) begin
        bx = bx + {1'b0, q[0], 6'd0};
        by = by + {1'b0, q[1], 6'd0};
        out_nxt.block_side = 3'd1;
      end else begin
        bx = {bx[6:0], 1'b0};
        by = {by[6:0], 1'b0};
        out_nxt.block_side = 3'd2;
      end
      out_nxt.pixel_color = item_r.mem_byte[k_r] ? fg : 16'd0;
      out_nxt.last_block  = (k_r == 3'd7);
    end else begin
      bx = {3'd0, col, k_r[0]};
      by = {3'd0, row};
      if (big) begin
        bx = bx + {2'd0, q[0], 5'd0};
        by = by + {2'd0, q[1], 5'd0};
        bx = {bx[6:0], 1'b0};
        by = {by[6:0], 1'b0};
        out_nxt.block_side = 3'd2;
      end else begin
        bx = {bx[5:0], 2'b00};
        by = {by[5:0], 2'b00};
        out_nxt.block_side = 3'd4;
      end
      out_nxt.pixel_color = lookup(k_r[0] ? item_r.mem_byte[7:4] : item_r.mem_byte[3:0],
                                   format_r[FMT_COL], c444_r);
      out_nxt.last_block  = k_r[0];
    end
    out_nxt.block_x = bx[6:0];
    out_nxt.block_y = by[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r       <= 1'b0;
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      val_r       <= val_nxt;
      k_r         <= k_nxt;
      out_valid_r <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (val_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
